/* rtl/wssi_pkg.sv */
// Shared types and constants for the waypoint smoothstep interpolator.
// No dependencies; imported by waypoint_smoothstep_interpolator.
`default_nettype none
package wssi_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_MOVE    = 2'd3
  } req_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_LOAD,
    ST_SQ_SET,
    ST_SQ_MUL,
    ST_SC_MUL,
    ST_SQRT,
    ST_DIV_LEN,
    ST_PROG,
    ST_DIV_T,
    ST_TSQ,
    ST_EASE,
    ST_CO_SET,
    ST_CO_MUL,
    ST_OUT
  } state_t;

  typedef logic signed [15:0] coord_t;

  localparam int unsigned ACC_W = 54;

  // ms per s, squared, folded into one scale
  localparam logic [19:0] SCALE_MS = 20'd1000000;
  // 3 in Q2.16 for the smoothstep polynomial
  localparam logic [17:0] EASE_K = 18'd196608;
  // top square-root trial bit for a 54-bit radicand
  localparam logic [ACC_W-1:0] SQRT_TOP = {2'b01, {(ACC_W - 2){1'b0}}};

  localparam logic [2:0] ADDR_INTERVAL = 3'd0;
  localparam logic [9:0] INTERVAL_RESET = 10'd20;

endpackage
`default_nettype wire

/* rtl/waypoint_smoothstep_interpolator.sv */
// Waypoint queue with smoothstep interpolation, bit-serial datapath.
// Depends on wssi_pkg (types, codes, constants).
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   req_type, pos_x/y/z, grip_value, speed, now_ms
//   out       output     out_valid/out_stall cmd_valid, cmd_x/y/z, cmd_grip, accepted, ...
//   cfg       APB        psel/penable        update_interval_ms at byte address 0
//
// Enqueue, clear, move-now and ignored ticks are handled in dispatch; a tick in a move
// and a tick that starts a move run the serial datapath: one shift-add multiplier, one
// restoring divider and a two-bit-per-step square root each work one bit per cycle.
// Reset is synchronous and empties the queue; queue entries are not cleared.
// in_stall is high while an item is being worked; a result waits in the output
// register while out_stall is high and the next item may already be accepted.
`default_nettype none
module waypoint_smoothstep_interpolator #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [1:0]                           req_type,
  input  wire  signed [15:0]                   pos_x,
  input  wire  signed [15:0]                   pos_y,
  input  wire  signed [15:0]                   pos_z,
  input  wire  signed [15:0]                   grip_value,
  input  wire  [15:0]                          speed,
  input  wire  [31:0]                          now_ms,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 cmd_valid,
  output logic signed [15:0]                   cmd_x,
  output logic signed [15:0]                   cmd_y,
  output logic signed [15:0]                   cmd_z,
  output logic signed [15:0]                   cmd_grip,
  output logic                                 accepted,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   queue_count,
  output logic                                 busy_res,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [2:0]                           paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import wssi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // configuration register
  logic [9:0] interval;
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_INTERVAL) begin
      interval <= pwdata[9:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_INTERVAL) ? {22'd0, interval} : 32'd0;

  state_t state, state_next;

  // captured request
  req_t        ir_req;
  coord_t      ir_pos [4];
  logic [15:0] ir_spd;
  logic [31:0] ir_now;
  logic        in_fire;
  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ir_req     <= req_t'(req_type);
      ir_pos[0]  <= pos_x;
      ir_pos[1]  <= pos_y;
      ir_pos[2]  <= pos_z;
      ir_pos[3]  <= grip_value;
      ir_spd     <= speed;
      ir_now     <= now_ms;
    end
  end

  // waypoint queue storage
  logic [47:0] queue_xyz [QUEUE_DEPTH];
  logic [31:0] queue_gs  [QUEUE_DEPTH];
  logic [47:0] rd_xyz;
  logic [31:0] rd_gs;
  logic        wr_en;
  logic [PTR_W-1:0] write_ptr, write_ptr_next, read_ptr, read_ptr_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_xyz[write_ptr] <= {ir_pos[2], ir_pos[1], ir_pos[0]};
      queue_gs[write_ptr]  <= {ir_spd, ir_pos[3]};
    end
    rd_xyz <= queue_xyz[read_ptr];
    rd_gs  <= queue_gs[read_ptr];
  end

  // control and datapath registers
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic             moving, moving_next;
  logic [31:0]      last_tick, last_tick_next;
  logic [31:0]      move_start, move_start_next;
  logic [31:0]      move_length, move_length_next;
  coord_t           start_pose [4];
  coord_t           start_pose_next [4];
  coord_t           target_pose [4];
  coord_t           target_pose_next [4];
  logic [15:0]      spd, spd_next;
  logic [ACC_W-1:0] opa, opa_next, acc, acc_next, rt, rt_next;
  logic [19:0]      opb, opb_next;
  logic [31:0]      rem, rem_next, quo, quo_next, dvs, dvs_next;
  logic [4:0]       cnt, cnt_next;
  logic [1:0]       ci, ci_next;
  logic             w_cmdv, w_cmdv_next, w_acc, w_acc_next;
  coord_t           w_cmd [4];
  coord_t           w_cmd_next [4];

  // shared serial units
  logic [ACC_W-1:0] mul_sum;
  logic [ACC_W:0]   sq_trial;
  logic             sq_ge;
  logic [32:0]      div_sh;
  logic             div_ge;
  logic [31:0]      div_rem, div_quo;
  logic signed [16:0] dfull, dmag17, pe, co_sum;
  logic             dneg;
  logic [15:0]      dmag;
  logic [31:0]      elapsed, tick_gap;
  logic             out_fire;

  assign mul_sum  = acc + (opb[0] ? opa : '0);
  assign sq_trial = {1'b0, rt} + {1'b0, opa};
  assign sq_ge    = {1'b0, acc} >= sq_trial;
  assign div_sh   = {rem, (state == ST_DIV_LEN) ? opa[26] : 1'b0};
  assign div_ge   = div_sh >= {1'b0, dvs};
  assign div_rem  = div_ge ? 32'(div_sh - {1'b0, dvs}) : div_sh[31:0];
  assign div_quo  = {quo[30:0], div_ge};
  assign dfull    = {target_pose[ci][15], target_pose[ci]} - {start_pose[ci][15], start_pose[ci]};
  assign dneg     = dfull[16];
  assign dmag17   = dneg ? -dfull : dfull;
  assign dmag     = dmag17[15:0];
  assign pe       = {1'b0, mul_sum[31:16]};
  assign co_sum   = {start_pose[ci][15], start_pose[ci]} + (dneg ? -pe : pe);
  assign elapsed  = ir_now - move_start;
  assign tick_gap = ir_now - last_tick;
  assign out_fire = (state == ST_OUT) && (!out_valid || !out_stall);

  // sequencer
  always_comb begin
    state_next       = state;
    write_ptr_next   = write_ptr;
    read_ptr_next    = read_ptr;
    entry_count_next = entry_count;
    moving_next      = moving;
    last_tick_next   = last_tick;
    move_start_next  = move_start;
    move_length_next = move_length;
    start_pose_next  = start_pose;
    target_pose_next = target_pose;
    spd_next         = spd;
    opa_next         = opa;
    opb_next         = opb;
    acc_next         = acc;
    rt_next          = rt;
    rem_next         = rem;
    quo_next         = quo;
    dvs_next         = dvs;
    cnt_next         = cnt;
    ci_next          = ci;
    w_cmdv_next      = w_cmdv;
    w_acc_next       = w_acc;
    w_cmd_next       = w_cmd;
    wr_en            = 1'b0;

    // shift-add step used by every multiply state
    if (state == ST_SQ_MUL || state == ST_SC_MUL || state == ST_TSQ ||
        state == ST_EASE || state == ST_CO_MUL) begin
      acc_next = mul_sum;
      opa_next = opa << 1;
      opb_next = opb >> 1;
      cnt_next = cnt - 5'd1;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          w_cmdv_next = 1'b0;
          w_acc_next  = 1'b0;
          for (int i = 0; i < 4; i++) w_cmd_next[i] = '0;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        state_next = ST_OUT;
        unique case (ir_req)
          REQ_ENQUEUE: begin
            if (entry_count < CNT_FULL) begin
              wr_en            = 1'b1;
              write_ptr_next   = (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
              entry_count_next = entry_count + 1'b1;
              w_acc_next       = 1'b1;
            end
          end
          REQ_TICK: begin
            if (tick_gap >= {22'd0, interval}) begin
              last_tick_next = ir_now;
              if (moving) begin
                state_next = ST_PROG;
              end else if (entry_count != '0) begin
                state_next = ST_LOAD;
              end
            end
          end
          REQ_CLEAR: begin
            write_ptr_next = '0;
            read_ptr_next = '0;
            entry_count_next = '0;
            moving_next = 1'b0;
          end
          REQ_MOVE: begin
            write_ptr_next = '0;
            read_ptr_next = '0;
            entry_count_next = '0;
            moving_next = 1'b0;
            w_cmdv_next = 1'b1;
            w_cmd_next = ir_pos;
          end
        endcase
      end
      // dequeue the waypoint and set up the move; a zero speed goes straight to the waypoint
      ST_LOAD: begin
        read_ptr_next       = (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;
        entry_count_next    = entry_count - 1'b1;
        start_pose_next     = ir_pos;
        target_pose_next[0] = rd_xyz[15:0];
        target_pose_next[1] = rd_xyz[31:16];
        target_pose_next[2] = rd_xyz[47:32];
        target_pose_next[3] = rd_gs[15:0];
        spd_next            = rd_gs[31:16];
        if (rd_gs[31:16] == 16'd0) begin
          w_cmdv_next   = 1'b1;
          w_cmd_next[0] = rd_xyz[15:0];
          w_cmd_next[1] = rd_xyz[31:16];
          w_cmd_next[2] = rd_xyz[47:32];
          w_cmd_next[3] = rd_gs[15:0];
          state_next    = ST_OUT;
        end else begin
          acc_next   = '0;
          ci_next    = 2'd0;
          state_next = ST_SQ_SET;
        end
      end
      // squared distance, one axis at a time
      ST_SQ_SET: begin
        opa_next   = ACC_W'(dmag);
        opb_next   = 20'(dmag);
        cnt_next   = 5'd15;
        state_next = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        if (cnt == 5'd0) begin
          if (ci == 2'd2) begin
            opa_next   = mul_sum;
            opb_next   = SCALE_MS;
            acc_next   = '0;
            cnt_next   = 5'd19;
            state_next = ST_SC_MUL;
          end else begin
            ci_next    = ci + 2'd1;
            state_next = ST_SQ_SET;
          end
        end
      end
      ST_SC_MUL: begin
        if (cnt == 5'd0) begin
          rt_next    = '0;
          opa_next   = SQRT_TOP;
          cnt_next   = 5'd26;
          state_next = ST_SQRT;
        end
      end
      // integer square root, two radicand bits a step
      ST_SQRT: begin
        if (sq_ge) begin
          acc_next = acc - sq_trial[ACC_W-1:0];
          rt_next  = (rt >> 1) + opa;
        end else begin
          rt_next  = rt >> 1;
        end
        opa_next = opa >> 2;
        cnt_next = cnt - 5'd1;
        if (cnt == 5'd0) begin
          opa_next   = ACC_W'(rt_next[26:0]);
          rem_next   = '0;
          quo_next   = '0;
          dvs_next   = {16'd0, spd};
          cnt_next   = 5'd26;
          state_next = ST_DIV_LEN;
        end
      end
      // move length from root over speed, at least one update interval
      ST_DIV_LEN: begin
        rem_next = div_rem;
        quo_next = div_quo;
        opa_next = opa << 1;
        cnt_next = cnt - 5'd1;
        if (cnt == 5'd0) begin
          move_length_next = (div_quo < {22'd0, interval}) ? {22'd0, interval} : div_quo;
          move_start_next  = ir_now;
          moving_next      = 1'b1;
          state_next       = ST_PROG;
        end
      end
      ST_PROG: begin
        if (elapsed >= move_length) begin
          w_cmdv_next = 1'b1;
          w_cmd_next  = target_pose;
          moving_next = 1'b0;
          state_next  = ST_OUT;
        end else begin
          rem_next   = elapsed;
          dvs_next   = move_length;
          quo_next   = '0;
          opa_next   = '0;
          cnt_next   = 5'd15;
          state_next = ST_DIV_T;
        end
      end
      // progress in Q0.16
      ST_DIV_T: begin
        rem_next = div_rem;
        quo_next = div_quo;
        cnt_next = cnt - 5'd1;
        if (cnt == 5'd0) begin
          opa_next   = ACC_W'(div_quo[15:0]);
          opb_next   = 20'(div_quo[15:0]);
          acc_next   = '0;
          state_next = ST_TSQ;
          cnt_next   = 5'd15;
        end
      end
      ST_TSQ: begin
        if (cnt == 5'd0) begin
          opa_next   = mul_sum;
          opb_next   = 20'(EASE_K - {1'b0, quo[15:0], 1'b0});
          acc_next   = '0;
          cnt_next   = 5'd17;
          state_next = ST_EASE;
        end
      end
      ST_EASE: begin
        if (cnt == 5'd0) begin
          quo_next   = {16'd0, mul_sum[47:32]};
          ci_next    = 2'd0;
          state_next = ST_CO_SET;
        end
      end
      // scale each axis by the eased progress
      ST_CO_SET: begin
        opa_next   = ACC_W'(quo[15:0]);
        opb_next   = 20'(dmag);
        acc_next   = '0;
        cnt_next   = 5'd15;
        state_next = ST_CO_MUL;
      end
      ST_CO_MUL: begin
        if (cnt == 5'd0) begin
          w_cmd_next[ci] = co_sum[15:0];
          if (ci == 2'd3) begin
            w_cmdv_next = 1'b1;
            state_next  = ST_OUT;
          end else begin
            ci_next    = ci + 2'd1;
            state_next = ST_CO_SET;
          end
        end
      end
      ST_OUT: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_ptr   <= '0;
      read_ptr    <= '0;
      entry_count <= '0;
      moving      <= 1'b0;
      last_tick   <= '0;
      move_start  <= '0;
      move_length <= '0;
      for (int i = 0; i < 4; i++) begin
        start_pose[i]  <= '0;
        target_pose[i] <= '0;
      end
    end else begin
      state       <= state_next;
      write_ptr   <= write_ptr_next;
      read_ptr    <= read_ptr_next;
      entry_count <= entry_count_next;
      moving      <= moving_next;
      last_tick   <= last_tick_next;
      move_start  <= move_start_next;
      move_length <= move_length_next;
      start_pose  <= start_pose_next;
      target_pose <= target_pose_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    spd    <= spd_next;
    opa    <= opa_next;
    opb    <= opb_next;
    acc    <= acc_next;
    rt     <= rt_next;
    rem    <= rem_next;
    quo    <= quo_next;
    dvs    <= dvs_next;
    cnt    <= cnt_next;
    ci     <= ci_next;
    w_cmdv <= w_cmdv_next;
    w_acc  <= w_acc_next;
    w_cmd  <= w_cmd_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      cmd_valid   <= w_cmdv;
      cmd_x       <= w_cmd[0];
      cmd_y       <= w_cmd[1];
      cmd_z       <= w_cmd[2];
      cmd_grip    <= w_cmd[3];
      accepted    <= w_acc;
      queue_count <= entry_count;
      busy_res    <= moving || (entry_count != '0);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_FULL) else $error("queue count above depth");

  a_ptr_agree: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0 || entry_count == CNT_FULL) == (write_ptr == read_ptr))
    else $error("queue pointers disagree with count");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_DISP) else $error("accepted request not dispatched");

  a_acc_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && cmd_valid)) else $error("enqueue result carries command");

  a_move_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_T) |-> moving && (rem < dvs)) else $error("progress divide out of range");

endmodule
`default_nettype wire
